@@ hw/rtl/ps2mct_pkg.sv @@
// Shared types, constants and helpers for the PS/2 mouse cursor tracker.
// No dependencies; compiled first.
`default_nettype none

package ps2mct_pkg;

    // Internal cursor position width.
    localparam int POS_WIDTH = 12;
    // Width of the coordinate fields and limit registers.
    localparam int COORD_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Signed width that holds position plus delta and the limit registers.
    localparam int CW = ((POS_WIDTH > COORD_W) ? POS_WIDTH : COORD_W) + 2;

    localparam int POS_MAX_I = (1 << POS_WIDTH) - 1;
    localparam logic signed [CW-1:0] POS_MAX_C = CW'(POS_MAX_I);

    localparam logic [POS_WIDTH-1:0] POS_RESET_X = POS_WIDTH'((960 > POS_MAX_I) ? POS_MAX_I : 960);
    localparam logic [POS_WIDTH-1:0] POS_RESET_Y = POS_WIDTH'((540 > POS_MAX_I) ? POS_MAX_I : 540);

    localparam logic [COORD_W-1:0] MAX_X_RESET = COORD_W'(1919);
    localparam logic [COORD_W-1:0] MAX_Y_RESET = COORD_W'(1079);

    // Header byte bit positions.
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    typedef enum logic [0:0] {
        REG_MAX_X = 1'b0,
        REG_MAX_Y = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               btn_left;
        logic               btn_right;
        logic               btn_middle;
    } result_t;

    // Limit register saturated to the position range.
    function automatic logic signed [CW-1:0] limit_of(input logic [COORD_W-1:0] m);
        logic signed [CW-1:0] v;
        v = $signed({{(CW-COORD_W){1'b0}}, m});
        return (v > POS_MAX_C) ? POS_MAX_C : v;
    endfunction

    function automatic logic signed [CW-1:0] clamp_pos(input logic signed [CW-1:0] v,
                                                       input logic signed [CW-1:0] hi);
        logic signed [CW-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ps2mct_ifs.sv @@
// Valid/ready channel interfaces for the mouse byte input and the cursor result.
// Depends on ps2mct_pkg.
`default_nettype none

interface ps2mct_in_if;
    logic                         valid;
    logic                         ready;
    logic [ps2mct_pkg::BYTE_W-1:0] data_byte;
    logic                         from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface ps2mct_out_if;
    logic                          valid;
    logic                          ready;
    logic [ps2mct_pkg::COORD_W-1:0] cursor_x;
    logic [ps2mct_pkg::COORD_W-1:0] cursor_y;
    logic                          btn_left;
    logic                          btn_right;
    logic                          btn_middle;

    modport source (output valid, output cursor_x, output cursor_y, output btn_left,
                    output btn_right, output btn_middle, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input btn_left,
                    input btn_right, input btn_middle, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ps2_mouse_cursor_tracker.sv @@
// Top level of the PS/2 mouse cursor tracker: channels, APB registers, result buffer.
// Depends on ps2mct_pkg, ps2mct_ifs and ps2mct_decode.
//
// Usage:
//   in_ch  - one mouse byte per beat (data_byte, from_aux). Bytes with from_aux
//            low are dropped. Three-byte packets; a header without bit 3 is
//            skipped to resync.
//   out_ch - one beat per completed packet: clamped cursor_x/cursor_y and the
//            three button bits.
//   APB    - max_x at 0x0, max_y at 0x4 (12 bits, read back). Write only while idle.
// Throughput: one byte per cycle while in_ch.ready is high; the packet logic is a single registered pass.
// The third byte's result is registered in the output register, or in the skid entry while the receiver stalls.
// A two-entry result buffer (output register plus skid) decouples the sides:
// in_ch.ready drops only while the skid entry is full, so that both entries hold results.
// Reset: cursor at 960,540, limits 1919/1079, packet phase back at header,
// result buffer empty.
`default_nettype none

module ps2_mouse_cursor_tracker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ps2mct_in_if.sink                           in_ch,
    ps2mct_out_if.source                        out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ps2mct_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ps2mct_pkg::APB_DW-1:0]  pwdata,
    output logic      [ps2mct_pkg::APB_DW-1:0]  prdata,
    output logic                                pready
);
    import ps2mct_pkg::*;

    logic [COORD_W-1:0] max_x_reg, max_y_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_X: prdata = {{(APB_DW-COORD_W){1'b0}}, max_x_reg};
            REG_MAX_Y: prdata = {{(APB_DW-COORD_W){1'b0}}, max_y_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAX_X: max_x_reg <= pwdata[COORD_W-1:0];
                REG_MAX_Y: max_y_reg <= pwdata[COORD_W-1:0];
                default:   ;
            endcase
        end
    end

    // packet decoder
    assign in_ch.ready = !skid_valid_reg;
    assign accept      = in_ch.valid && in_ch.ready;

    ps2mct_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .from_aux  (in_ch.from_aux),
        .max_x     (max_x_reg),
        .max_y     (max_y_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result buffer: output register plus skid entry
    assign pop = out_valid_reg && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cursor_x   = out_data_reg.cursor_x;
    assign out_ch.cursor_y   = out_data_reg.cursor_y;
    assign out_ch.btn_left   = out_data_reg.btn_left;
    assign out_ch.btn_right  = out_data_reg.btn_right;
    assign out_ch.btn_middle = out_data_reg.btn_middle;

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_out_drop_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("result beat dropped while receiver stalled");

    a_result_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (accept && !skid_valid_reg))
        else $error("result produced without an accepted byte or with buffer full");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == REG_MAX_X) |=> max_x_reg == $past(pwdata[COORD_W-1:0]))
        else $error("max_x write lost");

endmodule

`default_nettype wire

@@ hw/rtl/ps2mct_decode.sv @@
// Packet assembly state machine and cursor add/clamp datapath.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_decode (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [ps2mct_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                           from_aux,
    input  wire logic [ps2mct_pkg::COORD_W-1:0] max_x,
    input  wire logic [ps2mct_pkg::COORD_W-1:0] max_y,
    output logic                                res_valid,
    output ps2mct_pkg::result_t                 res
);
    import ps2mct_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    header_reg, header_next;
    logic [BYTE_W-1:0]    dx_byte_reg, dx_byte_next;
    logic [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [POS_WIDTH-1:0] pos_y_reg, pos_y_next;

    logic                 take;
    logic signed [CW-1:0] dx, dy, sum_x, sum_y, new_x, new_y;

    assign take = accept && from_aux;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        dx_byte_next = dx_byte_reg;
        if (take)
        begin
            case (phase_reg)
                PH_DX:
                begin
                    dx_byte_next = data_byte;
                    phase_next   = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    if (data_byte[HDR_SYNC])
                    begin
                        header_next = data_byte;
                        phase_next  = PH_DX;
                    end
                end
            endcase
        end
    end

    // outputs and cursor update
    always_comb
    begin
        dx    = $signed({{(CW-9){header_reg[HDR_XSIGN]}}, header_reg[HDR_XSIGN], dx_byte_reg});
        dy    = $signed({{(CW-9){header_reg[HDR_YSIGN]}}, header_reg[HDR_YSIGN], data_byte});
        sum_x = $signed({{(CW-POS_WIDTH){1'b0}}, pos_x_reg}) + dx;
        sum_y = $signed({{(CW-POS_WIDTH){1'b0}}, pos_y_reg}) - dy;
        new_x = clamp_pos(sum_x, limit_of(max_x));
        new_y = clamp_pos(sum_y, limit_of(max_y));

        res_valid      = take && (phase_reg == PH_DY);
        res.cursor_x   = new_x[COORD_W-1:0];
        res.cursor_y   = new_y[COORD_W-1:0];
        res.btn_left   = header_reg[HDR_LEFT];
        res.btn_right  = header_reg[HDR_RIGHT];
        res.btn_middle = header_reg[HDR_MIDDLE];

        pos_x_next = res_valid ? new_x[POS_WIDTH-1:0] : pos_x_reg;
        pos_y_next = res_valid ? new_y[POS_WIDTH-1:0] : pos_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            header_reg  <= '0;
            dx_byte_reg <= '0;
            pos_x_reg   <= POS_RESET_X;
            pos_y_reg   <= POS_RESET_Y;
        end
        else
        begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            dx_byte_reg <= dx_byte_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

endmodule

`default_nettype wire
